### sv/cpr_pkg.sv
// package: widths and cell control type for the clock page replacement block
`timescale 1ns / 1ps

package cpr_pkg;

   // fixed field widths of the request and response beats
   localparam int PAGE_W  = 16;
   localparam int INDEX_W = 2;

   // per-cell control, driven by the sequencer in the top level
   typedef struct packed {
      logic shift;     // take the neighbor's contents
      logic load;      // write the requested page, mark valid
      logic set_ref;   // set the reference bit
      logic clr_ref;   // clear the reference bit
   } cell_ctl_type;

endpackage

### sv/cpr_if.sv
// interfaces: request and response channels with valid/ready handshake
`timescale 1ns / 1ps

interface cpr_req_if import cpr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface cpr_rsp_if import cpr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic [INDEX_W-1:0] frame_index;
   logic               evicted_valid;
   logic [PAGE_W-1:0]  evicted_page;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, output ready);
endinterface

### sv/cpr_cell.sv
// one frame cell of the rotating ring: page, valid mark and reference bit
`timescale 1ns / 1ps

module cpr_cell
   import cpr_pkg::*;
#(
   parameter int PAGE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  logic [PAGE_BITS-1:0] req_page,
   input  logic [PAGE_BITS-1:0] nbr_page,
   input  logic                 nbr_valid,
   input  logic                 nbr_ref,
   output logic [PAGE_BITS-1:0] out_page,
   output logic                 out_valid,
   output logic                 out_ref,
   output logic [PAGE_BITS-1:0] held_page,
   output logic                 held_valid,
   output logic                 held_ref,
   output logic                 match
);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 valid_ff, valid_in;
   logic                 ref_ff, ref_in;

   // contents after this cycle's local update, also handed to the neighbor
   always_comb begin
      out_page  = ctl.load ? req_page : page_ff;
      out_valid = valid_ff | ctl.load;
      if (ctl.set_ref) begin
         out_ref = 1'b1;
      end else if (ctl.clr_ref) begin
         out_ref = 1'b0;
      end else begin
         out_ref = ref_ff;
      end
   end

   // stored contents before any update this cycle
   assign held_page  = page_ff;
   assign held_valid = valid_ff;
   assign held_ref   = ref_ff;

   // rotate or keep
   always_comb begin
      page_in  = ctl.shift ? nbr_page  : out_page;
      valid_in = ctl.shift ? nbr_valid : out_valid;
      ref_in   = ctl.shift ? nbr_ref   : out_ref;
   end

   // resident compare against the request
   assign match = valid_ff && (page_ff == req_page);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ref_ff   <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         ref_ff   <= ref_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

endmodule

### sv/clock_page_replacement_top.sv
// Clock (second chance) page replacement over a rotating ring of frame cells.
// Hit: the page is registered, matched in every cell, and the response registered.
// Miss: the hand sweeps, one ring rotation per cycle, clearing each set reference bit it
// passes (at most FRAMES), then loads the frame at the hand when the response slot is free.
// One request in flight at a time; a response not yet taken holds the sequencer.
// Reset: all frames invalid, reference bits set, hand at frame 0, no response held.
`timescale 1ns / 1ps

module clock_page_replacement_top
   import cpr_pkg::*;
#(
   parameter int FRAMES    = 4,
   parameter int PAGE_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   cpr_req_if.sink   req_bus,
   cpr_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(FRAMES);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MATCH = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   // physical frame index currently sitting in cell 0 (the hand)
   logic [IDX_W-1:0]     hand_ff, hand_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               hit_ff, hit_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               ev_valid_ff, ev_valid_in;
   logic [PAGE_W-1:0]  ev_page_ff, ev_page_in;

   cell_ctl_type         ctl [FRAMES];
   logic [PAGE_BITS-1:0] cell_page [FRAMES];
   logic                 cell_valid [FRAMES];
   logic                 cell_ref [FRAMES];
   logic                 cell_match [FRAMES];
   logic [PAGE_BITS-1:0] held_page [FRAMES];
   logic                 held_valid [FRAMES];
   logic                 held_ref [FRAMES];

   logic                 cell_ref_head;
   logic                 cell_valid_head;
   logic [PAGE_BITS-1:0] cell_page_head;

   logic             accept, slot_free, any_hit, do_hit, do_load, do_clr;
   logic [IDX_W-1:0] hit_pos, hand_next;
   logic [IDX_W:0]   hit_sum, hit_phys;

   // ring of cells, each fed by its right-hand neighbor
   for (genvar gi = 0; gi < FRAMES; gi++) begin : g_cell
      cpr_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl[gi]),
         .req_page   (page_ff),
         .nbr_page   (cell_page[(gi + 1) % FRAMES]),
         .nbr_valid  (cell_valid[(gi + 1) % FRAMES]),
         .nbr_ref    (cell_ref[(gi + 1) % FRAMES]),
         .out_page   (cell_page[gi]),
         .out_valid  (cell_valid[gi]),
         .out_ref    (cell_ref[gi]),
         .held_page  (held_page[gi]),
         .held_valid (held_valid[gi]),
         .held_ref   (held_ref[gi]),
         .match      (cell_match[gi])
      );
   end

   // stored contents of the cell at the hand
   assign cell_ref_head   = held_ref[0];
   assign cell_valid_head = held_valid[0];
   assign cell_page_head  = held_page[0];

   assign accept         = req_bus.valid && req_bus.ready;
   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign slot_free      = !rsp_valid_ff || rsp_bus.ready;

   // hit detect and position encode (a page is resident at most once)
   always_comb begin
      any_hit = 1'b0;
      hit_pos = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (cell_match[i]) begin
            any_hit = 1'b1;
            hit_pos = hit_pos | IDX_W'(i);
         end
      end
   end

   // cell position to physical frame index
   always_comb begin
      hit_sum  = {1'b0, hand_ff} + {1'b0, hit_pos};
      hit_phys = (hit_sum >= (IDX_W + 1)'(FRAMES)) ? hit_sum - (IDX_W + 1)'(FRAMES) : hit_sum;
   end

   assign hand_next = (hand_ff == IDX_W'(FRAMES - 1)) ? '0 : hand_ff + 1'b1;

   // sequencer decisions
   always_comb begin
      do_hit  = (state_ff == ST_MATCH) && any_hit && slot_free;
      do_clr  = (state_ff == ST_SCAN) && cell_ref_head;
      do_load = (state_ff == ST_SCAN) && !cell_ref_head && slot_free;
   end

   // cell control
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         ctl[i].shift   = do_clr || do_load;
         ctl[i].load    = (i == 0) && do_load;
         ctl[i].clr_ref = (i == 0) && do_clr;
         ctl[i].set_ref = ((i == 0) && do_load) || (do_hit && cell_match[i]);
      end
   end

   // next state, hand and response
   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      hand_in      = hand_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      hit_in       = hit_ff;
      index_in     = index_ff;
      ev_valid_in  = ev_valid_ff;
      ev_page_in   = ev_page_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               page_in  = PAGE_BITS'(req_bus.page_number);
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (!any_hit) begin
               state_in = ST_SCAN;
            end else if (do_hit) begin
               rsp_valid_in = 1'b1;
               hit_in       = 1'b1;
               index_in     = INDEX_W'(hit_phys);
               ev_valid_in  = 1'b0;
               ev_page_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (do_clr) begin
               hand_in = hand_next;
            end else if (do_load) begin
               rsp_valid_in = 1'b1;
               hit_in       = 1'b0;
               index_in     = INDEX_W'(hand_ff);
               ev_valid_in  = cell_valid_head;
               ev_page_in   = cell_valid_head ? PAGE_W'(cell_page_head) : '0;
               hand_in      = hand_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hit           = hit_ff;
   assign rsp_bus.frame_index   = index_ff;
   assign rsp_bus.evicted_valid = ev_valid_ff;
   assign rsp_bus.evicted_page  = ev_page_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hand_ff      <= hand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      hit_ff      <= hit_in;
      index_ff    <= index_in;
      ev_valid_ff <= ev_valid_in;
      ev_page_ff  <= ev_page_in;
   end

endmodule

### tb/clock_page_replacement_top_tb.sv
// testbench: clock page replacement block, directed table then predictor-checked random pages
`timescale 1ns / 1ps

module clock_page_replacement_top_tb;
   import cpr_pkg::*;

   localparam int FRAMES      = 4;
   localparam int POOL_SIZE   = 6;
   localparam int PHASE_ITEMS = 100;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 16;

   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] frame_index;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
   } page_result_type;

   // one directed row: page, and optionally a hand-written expected response
   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic               typed;
      logic               hit;
      logic [INDEX_W-1:0] frame_index;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
   } access_row_type;

   // travels with the request beat so the monitor knows what to expect
   typedef struct packed {
      logic            typed;
      page_result_type want;
   } access_note_type;

   localparam int DIRECTED_ROWS = 19;

   // after reset: all frames empty, all reference bits set, hand at frame 0
   access_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'h0000, 1'b1, 1'b0, 2'd0, 1'b0, 16'h0000},  // full sweep over empty frames
      '{16'hFFFF, 1'b1, 1'b0, 2'd1, 1'b0, 16'h0000},  // empty frame with cleared bit
      '{16'h0000, 1'b1, 1'b1, 2'd0, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b1, 1'b1, 2'd1, 1'b0, 16'h0000},
      '{16'h8000, 1'b1, 1'b0, 2'd2, 1'b0, 16'h0000},
      '{16'h0001, 1'b1, 1'b0, 2'd3, 1'b0, 16'h0000},
      '{16'h1234, 1'b1, 1'b0, 2'd0, 1'b1, 16'h0000},  // all bits set, evict at hand
      '{16'h0000, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},
      '{16'h1234, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},
      '{16'h5555, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},
      '{16'hAAAA, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},
      '{16'h5555, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},
      '{16'h0000, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},
      '{16'h7FFF, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},  // second chance then replace
      '{16'h0000, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},
      '{16'h8001, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},
      '{16'hAAAA, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000},
      '{16'h2AAA, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   cpr_req_if req_bus ();
   cpr_rsp_if rsp_bus ();

   clock_page_replacement_top #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_W)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predictor copy of the frame ring
   logic [PAGE_W-1:0] resident_page  [FRAMES];
   bit                resident_valid [FRAMES];
   bit                ref_mark       [FRAMES];
   int                hand;

   page_result_type   lookup_results_due [$];
   access_note_type   req_note;
   logic [PAGE_W-1:0] page_pool [POOL_SIZE];
   int                mismatch_count = 0;
   int                send_idle_pct  = 0;
   int                stall_pct      = 0;
   logic              rsp_hold       = 1'b0;
   int                hold_left;
   event              hold_kick;

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // clock lookup: hit search from the hand, else second-chance sweep
   function automatic page_result_type clock_lookup(input logic [PAGE_W-1:0] page);
      page_result_type r;
      int              pos;
      int              victim;
      bit              found;
      r     = '0;
      pos   = hand;
      found = 1'b0;
      for (int k = 0; k < FRAMES; k++) begin
         if (resident_valid[pos] && resident_page[pos] == page) begin
            ref_mark[pos] = 1'b1;
            r.hit         = 1'b1;
            r.frame_index = pos[INDEX_W-1:0];
            return r;
         end
         pos = (pos + 1) % FRAMES;
      end
      // miss: clear set bits until a clear one turns up
      pos    = hand;
      victim = hand;
      for (int k = 0; k < FRAMES && !found; k++) begin
         if (!ref_mark[pos]) begin
            victim = pos;
            found  = 1'b1;
         end else begin
            ref_mark[pos] = 1'b0;
            pos = (pos + 1) % FRAMES;
         end
      end
      r.frame_index = victim[INDEX_W-1:0];
      if (resident_valid[victim]) begin
         r.evicted_valid = 1'b1;
         r.evicted_page  = resident_page[victim];
      end
      resident_page[victim]  = page;
      resident_valid[victim] = 1'b1;
      ref_mark[victim]       = 1'b1;
      hand = (victim + 1) % FRAMES;
      return r;
   endfunction

   // receiver: random stalls, forced low during a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // long receiver hold-off, counted here
   always begin
      @(hold_kick);
      rsp_hold <= 1'b1;
      hold_left = HOLD_CYCLES;
      while (hold_left > 0) begin
         @(posedge clock);
         hold_left--;
      end
      rsp_hold <= 1'b0;
   end

   // monitor: check response beats first, then record request beats
   always @(posedge clock) begin
      page_result_type want;
      page_result_type predicted;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (lookup_results_due.size() == 0) begin
               report_mismatch("response beat with nothing outstanding");
            end else begin
               want = lookup_results_due.pop_front();
               check_field("hit", rsp_bus.hit, want.hit);
               check_field("frame_index", rsp_bus.frame_index, want.frame_index);
               check_field("evicted_valid", rsp_bus.evicted_valid, want.evicted_valid);
               check_field("evicted_page", rsp_bus.evicted_page, want.evicted_page);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted = clock_lookup(req_bus.page_number);
            if (req_note.typed)
               lookup_results_due.push_back(req_note.want);
            else
               lookup_results_due.push_back(predicted);
         end
      end
   end

   // one request beat, with random idle cycles in front
   task automatic send_page(input logic [PAGE_W-1:0] page, input access_note_type note);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid       <= 1'b0;
         req_bus.page_number <= PAGE_W'($urandom);
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.page_number <= page;
      req_note            <= note;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // mostly a small working set so hits and evictions both happen
   function automatic logic [PAGE_W-1:0] pick_page();
      if ($urandom_range(99) < 65)
         return page_pool[$urandom_range(POOL_SIZE - 1)];
      return PAGE_W'($urandom);
   endfunction

   task automatic refill_pool();
      foreach (page_pool[i])
         page_pool[i] = PAGE_W'($urandom);
   endtask

   task automatic send_random(input int count);
      access_note_type note;
      note = '0;
      for (int i = 0; i < count; i++)
         send_page(pick_page(), note);
   endtask

   // stimulus and end of run
   initial begin
      access_note_type note;
      int              idle_set [4];
      int              stall_set [4];
      req_bus.valid       <= 1'b0;
      req_bus.page_number <= '0;
      req_note            <= '0;
      idle_set  = '{0, 86, 0, 38};
      stall_set = '{0, 0, 86, 38};
      for (int k = 0; k < FRAMES; k++) begin
         resident_page[k]  = '0;
         resident_valid[k] = 1'b0;
         ref_mark[k]       = 1'b1;
      end
      hand = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         note.typed              = directed_rows[i].typed;
         note.want.hit           = directed_rows[i].hit;
         note.want.frame_index   = directed_rows[i].frame_index;
         note.want.evicted_valid = directed_rows[i].evicted_valid;
         note.want.evicted_page  = directed_rows[i].evicted_page;
         send_page(directed_rows[i].page, note);
      end

      // long receiver hold-off while requests keep coming
      refill_pool();
      -> hold_kick;
      send_random(24);

      // random phases with different idle and stall mixes
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_set[p];
         stall_pct    <= stall_set[p];
         refill_pool();
         send_random(PHASE_ITEMS);
      end
      req_bus.valid <= 1'b0;

      // drain
      @(posedge clock);
      while (lookup_results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("timeout at %0t ns", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### clock_page_replacement_top.f
sv/cpr_pkg.sv
sv/cpr_if.sv
sv/cpr_cell.sv
sv/clock_page_replacement_top.sv
tb/clock_page_replacement_top_tb.sv
